@@ src/sbsm_pkg.sv @@
package sbsm_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned OpW     = 2;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned MaddrW  = 18;
  localparam int unsigned RegW    = 5;
  localparam int unsigned MirW    = 2;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;

  localparam logic [CfgIdxW-1:0] CfgPrgBanks = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgChrBanks = 1'd1;

  localparam logic [OpW-1:0] OpCpuRd = 2'd0;
  localparam logic [OpW-1:0] OpCpuWr = 2'd1;
  localparam logic [OpW-1:0] OpPpuRd = 2'd2;
  localparam logic [OpW-1:0] OpPpuWr = 2'd3;

  localparam logic [1:0] SelControl = 2'd0;
  localparam logic [1:0] SelChrLow  = 2'd1;
  localparam logic [1:0] SelChrHigh = 2'd2;
  localparam logic [1:0] SelPrgBank = 2'd3;

  localparam logic [RegW-1:0] LoadShiftInit = 5'h10;
  localparam logic [RegW-1:0] ControlInit   = 5'h0C;
  localparam logic [RegW-1:0] ControlFixHi  = 5'h0C;
  localparam logic [CfgW-1:0] PrgBanksInit  = 5'd16;
  localparam logic [CfgW-1:0] ChrBanksInit  = 5'd0;
  localparam logic [CfgW-1:0] MaxBanks      = 5'd16;

  typedef enum logic [2:0] {
    TgtNone   = 3'd0,
    TgtPrgRom = 3'd1,
    TgtPrgRam = 3'd2,
    TgtChrRom = 3'd3,
    TgtChrRam = 3'd4
  } target_e;

  typedef enum logic [2:0] {
    KindNone     = 3'd0,
    KindPrgRam   = 3'd1,
    KindPrgRom   = 3'd2,
    KindRegReset = 3'd3,
    KindRegShift = 3'd4,
    KindChr      = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] addr;
    logic             data0;
    logic             wr;
  } job_t;

  // Restoring remainder of a 5-bit value by a nonzero modulus of up to 32.
  function automatic logic [RegW-1:0] mod_small(input logic [RegW-1:0] a,
                                                input logic [RegW:0] m);
    logic [10:0] rem;
    logic [10:0] sub;
    rem = {6'd0, a};
    sub = '0;
    for (int i = 4; i >= 0; i--) begin
      sub = {5'd0, m} << i;
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
    return rem[RegW-1:0];
  endfunction

endpackage

@@ src/sbsm_if.sv @@
interface sbsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, output opcode, output bus_address, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input bus_address, input write_data,
                output ready);
endinterface

interface sbsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [17:0] mem_address;
  logic        write_enable;
  logic [1:0]  mirroring;
  logic        mirroring_update;

  modport source (output valid, output target, output mem_address, output write_enable,
                  output mirroring, output mirroring_update, input ready);
  modport sink (input valid, input target, input mem_address, input write_enable,
                input mirroring, input mirroring_update, output ready);
endinterface

@@ src/sbsm_front.sv @@
module sbsm_front (
  sbsm_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output sbsm_pkg::job_t job_o
);
  import sbsm_pkg::*;

  kind_e kind;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    kind = KindNone;
    if (!in_i.opcode[1]) begin
      if (in_i.bus_address[15]) begin
        if (in_i.opcode == OpCpuRd) begin
          kind = KindPrgRom;
        end else if (in_i.write_data[7]) begin
          kind = KindRegReset;
        end else begin
          kind = KindRegShift;
        end
      end else if (in_i.bus_address[14:13] == 2'b11) begin
        kind = KindPrgRam;
      end
    end else if (in_i.bus_address[15:13] == 3'd0) begin
      kind = KindChr;
    end
  end

  assign job_o.kind  = kind;
  assign job_o.addr  = in_i.bus_address;
  assign job_o.data0 = in_i.write_data[0];
  assign job_o.wr    = (in_i.opcode == OpCpuWr) || (in_i.opcode == OpPpuWr);

endmodule

@@ src/sbsm_queue.sv @@
module sbsm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbsm_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sbsm_pkg::job_t job_o
);
  import sbsm_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ src/sbsm_back.sv @@
module sbsm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sbsm_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                          empty_i,
  input  sbsm_pkg::job_t                job_i,
  output logic                          pop_o,
  sbsm_out_if.source                    out_o
);
  import sbsm_pkg::*;

  logic [CfgW-1:0]   prg_cfg_q, chr_cfg_q;
  logic [RegW-1:0]   shift_q, shift_d;
  logic [RegW-1:0]   ctrl_q, ctrl_d;
  logic [RegW-1:0]   chr_lo_q, chr_lo_d;
  logic [RegW-1:0]   chr_hi_q, chr_hi_d;
  logic [RegW-1:0]   prg_q, prg_d;
  logic              out_valid_q;
  target_e           tgt_q, tgt_d;
  logic [MaddrW-1:0] maddr_q, maddr_d;
  logic              we_q, we_d;
  logic [MirW-1:0]   mir_q;
  logic              upd_q, upd_d;

  logic [CfgW-1:0]   prg_n, chr_n;
  logic [RegW-1:0]   mod_a, mod_r, chr_bank, shift_nxt;
  logic [RegW:0]     mod_m;
  logic [1:0]        prg_layout;
  logic              upper;

  assign pop_o    = !empty_i && (!out_valid_q || out_o.ready);
  assign prg_layout = ctrl_q[3:2];
  assign upper    = job_i.addr[14];
  assign chr_bank = job_i.addr[12] ? chr_hi_q : chr_lo_q;
  assign shift_nxt = {job_i.data0, shift_q[RegW-1:1]};

  always_comb begin
    if (prg_cfg_q == '0) begin
      prg_n = CfgW'(1);
    end else if (prg_cfg_q > MaxBanks) begin
      prg_n = MaxBanks;
    end else begin
      prg_n = prg_cfg_q;
    end
    chr_n = (chr_cfg_q > MaxBanks) ? MaxBanks : chr_cfg_q;
  end

  always_comb begin
    mod_a = '0;
    mod_m = (RegW+1)'(1);
    if (job_i.kind == KindPrgRom) begin
      unique case (prg_layout)
        2'd0, 2'd1: begin
          mod_a = {2'b00, prg_q[3:1]};
          mod_m = (prg_n[4:1] == '0) ? (RegW+1)'(1) : {2'b00, prg_n[4:1]};
        end
        2'd2: begin
          mod_a = upper ? {1'b0, prg_q[3:0]} : '0;
          mod_m = {1'b0, prg_n};
        end
        default: begin
          mod_a = upper ? prg_n - 1'b1 : {1'b0, prg_q[3:0]};
          mod_m = {1'b0, prg_n};
        end
      endcase
    end else if (job_i.kind == KindChr && chr_n != '0) begin
      if (!ctrl_q[4]) begin
        mod_a = {1'b0, chr_lo_q[4:1]};
        mod_m = {1'b0, chr_n};
      end else begin
        mod_a = chr_bank;
        mod_m = {chr_n, 1'b0};
      end
    end
  end

  assign mod_r = mod_small(mod_a, mod_m);

  always_comb begin
    shift_d  = shift_q;
    ctrl_d   = ctrl_q;
    chr_lo_d = chr_lo_q;
    chr_hi_d = chr_hi_q;
    prg_d    = prg_q;
    tgt_d    = TgtNone;
    maddr_d  = '0;
    we_d     = 1'b0;
    upd_d    = 1'b0;
    unique case (job_i.kind)
      KindPrgRam: begin
        tgt_d   = TgtPrgRam;
        maddr_d = {5'd0, job_i.addr[12:0]};
        we_d    = job_i.wr;
      end
      KindPrgRom: begin
        tgt_d = TgtPrgRom;
        if (!prg_layout[1]) begin
          maddr_d = (prg_n == CfgW'(1)) ? {4'd0, job_i.addr[13:0]}
                                        : {mod_r[2:0], job_i.addr[14:0]};
        end else begin
          maddr_d = {mod_r[3:0], job_i.addr[13:0]};
        end
      end
      KindRegReset: begin
        shift_d = LoadShiftInit;
        ctrl_d  = ctrl_q | ControlFixHi;
      end
      KindRegShift: begin
        if (shift_q[0]) begin
          shift_d = LoadShiftInit;
          unique case (job_i.addr[14:13])
            SelControl: begin
              ctrl_d = shift_nxt;
              upd_d  = 1'b1;
            end
            SelChrLow:  chr_lo_d = shift_nxt;
            SelChrHigh: chr_hi_d = shift_nxt;
            default:    prg_d = shift_nxt;
          endcase
        end else begin
          shift_d = shift_nxt;
        end
      end
      KindChr: begin
        if (chr_n == '0) begin
          tgt_d = TgtChrRam;
          we_d  = job_i.wr;
          maddr_d = ctrl_q[4] ? {5'd0, chr_bank[0], job_i.addr[11:0]}
                              : {5'd0, job_i.addr[12:0]};
        end else begin
          tgt_d = TgtChrRom;
          maddr_d = ctrl_q[4] ? {1'b0, mod_r, job_i.addr[11:0]}
                              : {1'b0, mod_r[3:0], job_i.addr[12:0]};
        end
      end
      default: begin
        tgt_d = TgtNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cfg_q   <= PrgBanksInit;
      chr_cfg_q   <= ChrBanksInit;
      shift_q     <= LoadShiftInit;
      ctrl_q      <= ControlInit;
      chr_lo_q    <= '0;
      chr_hi_q    <= '0;
      prg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgPrgBanks: prg_cfg_q <= cfg_wdata_i;
          default:     chr_cfg_q <= cfg_wdata_i;
        endcase
      end
      if (pop_o) begin
        shift_q     <= shift_d;
        ctrl_q      <= ctrl_d;
        chr_lo_q    <= chr_lo_d;
        chr_hi_q    <= chr_hi_d;
        prg_q       <= prg_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tgt_q   <= tgt_d;
      maddr_q <= maddr_d;
      we_q    <= we_d;
      mir_q   <= ctrl_d[1:0];
      upd_q   <= upd_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.target           = tgt_q;
  assign out_o.mem_address      = maddr_q;
  assign out_o.write_enable     = we_q;
  assign out_o.mirroring        = mir_q;
  assign out_o.mirroring_update = upd_q;

endmodule

@@ src/serial_bank_switch_mapper_core.sv @@
// Address translator for a serial bank-switch cartridge mapper.
// Each beat on in_i is one CPU or PPU bus access: opcode, bus address and
// write data. Each accepted beat yields exactly one beat on out_o with the
// target memory, the byte address in it, its write enable and the current
// mirroring mode, plus a flag when the access committed the control register.
// The two configuration registers, program and character ROM bank counts,
// are written through cfg_we_i, cfg_index_i and cfg_wdata_i; the user must
// write them only while no access is in flight (not enforced by the block).
// A front stage classifies each access and writes it into a two-entry
// queue; a back stage holds the mapper registers, translates one access per
// cycle while the receiver takes its beats, and registers the result. An
// accepted access goes through the queue, then the output register; the
// rate of one access per cycle comes from the single translation step.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and in_i.ready drops once both queue entries are taken.
// Reset empties the queue and output register, sets the bank counts to 16
// and 0, the load register to its marker and the control register to 0x0C.
module serial_bank_switch_mapper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sbsm_pkg::CfgW-1:0]    cfg_wdata_i,
  sbsm_in_if.sink                       in_i,
  sbsm_out_if.source                    out_o
);
  import sbsm_pkg::*;

  logic push, pop, full, empty;
  job_t job_in, job_out;

  sbsm_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  sbsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  sbsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

@@ src/sbsm_checker.sv @@
module sbsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_target,
  input logic [17:0] out_mem_address,
  input logic        out_write_enable,
  input logic        out_mirroring_update
);
  import sbsm_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_target == TgtNone |-> out_mem_address == '0 && !out_write_enable)
    else $error("unmapped access carries an address or write enable");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_mirroring_update |-> out_target == TgtNone)
    else $error("control commit reported on a memory access");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_write_enable |-> out_target == TgtPrgRam || out_target == TgtChrRam)
    else $error("write enable on a read-only target");

endmodule

bind serial_bank_switch_mapper_core sbsm_checker u_sbsm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid            (out_o.valid),
  .out_ready            (out_o.ready),
  .out_target           (out_o.target),
  .out_mem_address      (out_o.mem_address),
  .out_write_enable     (out_o.write_enable),
  .out_mirroring_update (out_o.mirroring_update)
);

@@ tb/serial_bank_switch_mapper_core_checker.sv @@
`timescale 1ns / 1ps

module serial_bank_switch_mapper_core_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sbsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sbsm_pkg::CfgW-1:0]    cfg_wdata_i,
  sbsm_in_if                           access_mon,
  sbsm_out_if                          result_mon,
  output int                           fail_count_o,
  output int                           pending_o
);
  import sbsm_pkg::*;

  typedef struct packed {
    target_e     target;
    logic [17:0] mem_address;
    logic        write_enable;
    logic [1:0]  mirroring;
    logic        mirroring_update;
  } access_result_t;

  logic [CfgW-1:0] prg_banks_q;
  logic [CfgW-1:0] chr_banks_q;
  logic [RegW-1:0] shift_q;
  logic [RegW-1:0] ctrl_q;
  logic [RegW-1:0] chr_lo_q;
  logic [RegW-1:0] chr_hi_q;
  logic [RegW-1:0] prg_bank_q;

  access_result_t translations_q[$];
  access_result_t want;
  access_result_t got;
  int mismatches = 0;
  int waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic int unsigned prg_bank_count();
    int unsigned n;
    n = 32'(prg_banks_q);
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic int unsigned chr_bank_count();
    int unsigned n;
    n = 32'(chr_banks_q);
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic int unsigned prg_window16(int unsigned bank, logic [15:0] addr);
    return (bank % prg_bank_count()) * 32'h4000 + 32'(addr[13:0]);
  endfunction

  function automatic int unsigned prg_window32(int unsigned bank, logic [15:0] addr);
    int unsigned span;
    int unsigned halves;
    int unsigned idx;
    span   = prg_bank_count() * 32'h4000;
    halves = prg_bank_count() / 2;
    if (halves == 0) halves = 1;
    idx = (bank % halves) * 32'h8000 + 32'(addr[14:0]);
    if (idx >= span) idx = idx % span;
    return idx;
  endfunction

  function automatic int unsigned prg_rom_offset(logic [15:0] addr);
    logic upper;
    upper = addr >= 16'hC000;
    if (ctrl_q[3:2] <= 2'd1) return prg_window32(32'(prg_bank_q[3:1]), addr);
    if (ctrl_q[3:2] == 2'd2) return prg_window16(upper ? 32'(prg_bank_q[3:0]) : 0, addr);
    return prg_window16(upper ? prg_bank_count() - 1 : 32'(prg_bank_q[3:0]), addr);
  endfunction

  function automatic int unsigned chr_offset(logic [15:0] addr);
    int unsigned n;
    int unsigned bank;
    int unsigned idx;
    n = chr_bank_count();
    if (!ctrl_q[4]) begin
      bank = 32'(chr_lo_q[4:1]);
      if (n == 0) return 32'(addr[12:0]);
      return (bank % n) * 32'h2000 + 32'(addr[12:0]);
    end
    bank = 32'((addr < 16'h1000) ? chr_lo_q : chr_hi_q);
    idx = bank * 32'h1000 + 32'(addr[11:0]);
    if (n == 0) return idx & 32'h1FFF;
    return idx % (n * 32'h2000);
  endfunction

  // Translates one bus access and advances the mapper registers as the block does.
  function automatic access_result_t map_access(logic [1:0] op, logic [15:0] addr,
                                                logic [7:0] data);
    access_result_t r;
    int unsigned offset;
    logic commit;
    r = '0;
    r.target = TgtNone;
    offset = 0;
    if (op == OpCpuRd || op == OpCpuWr) begin
      if (addr >= 16'h6000 && addr < 16'h8000) begin
        r.target = TgtPrgRam;
        offset = 32'(addr - 16'h6000);
        r.write_enable = (op == OpCpuWr);
      end else if (addr >= 16'h8000) begin
        if (op == OpCpuRd) begin
          r.target = TgtPrgRom;
          offset = prg_rom_offset(addr);
        end else if (data[7]) begin
          shift_q = LoadShiftInit;
          ctrl_q = ctrl_q | ControlFixHi;
        end else begin
          commit = shift_q[0];
          shift_q = {data[0], shift_q[4:1]};
          if (commit) begin
            case (addr[14:13])
              SelControl: begin
                ctrl_q = shift_q;
                r.mirroring_update = 1'b1;
              end
              SelChrLow: chr_lo_q = shift_q;
              SelChrHigh: chr_hi_q = shift_q;
              default: prg_bank_q = shift_q;
            endcase
            shift_q = LoadShiftInit;
          end
        end
      end
    end else if (addr < 16'h2000) begin
      offset = chr_offset(addr);
      if (chr_bank_count() == 0) begin
        r.target = TgtChrRam;
        r.write_enable = (op == OpPpuWr);
      end else begin
        r.target = TgtChrRom;
      end
    end
    r.mem_address = offset[17:0];
    r.mirroring = ctrl_q[1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_banks_q = PrgBanksInit;
      chr_banks_q = ChrBanksInit;
      shift_q     = LoadShiftInit;
      ctrl_q      = ControlInit;
      chr_lo_q    = '0;
      chr_hi_q    = '0;
      prg_bank_q  = '0;
      translations_q.delete();
      waiting = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        got.target           = target_e'(result_mon.target);
        got.mem_address      = result_mon.mem_address;
        got.write_enable     = result_mon.write_enable;
        got.mirroring        = result_mon.mirroring;
        got.mirroring_update = result_mon.mirroring_update;
        if (translations_q.size() == 0) begin
          mismatches++;
          $display("%0t: result mismatch: expected no beat, actual target %0d addr %h",
                   $time, got.target, got.mem_address);
        end else begin
          want = translations_q.pop_front();
          if (got.target !== want.target || got.mem_address !== want.mem_address ||
              got.write_enable !== want.write_enable || got.mirroring !== want.mirroring ||
              got.mirroring_update !== want.mirroring_update) begin
            mismatches++;
            $display({"%0t: result mismatch: expected target %0d addr %h we %0d mir %0d",
                      " upd %0d, actual target %0d addr %h we %0d mir %0d upd %0d"},
                     $time, want.target, want.mem_address, want.write_enable,
                     want.mirroring, want.mirroring_update, got.target, got.mem_address,
                     got.write_enable, got.mirroring, got.mirroring_update);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPrgBanks) prg_banks_q = cfg_wdata_i;
        else chr_banks_q = cfg_wdata_i;
      end
      if (access_mon.valid && access_mon.ready)
        translations_q.push_back(map_access(access_mon.opcode, access_mon.bus_address,
                                            access_mon.write_data));
      waiting = translations_q.size();
    end
  end

endmodule

@@ tb/serial_bank_switch_mapper_core_tb.sv @@
`timescale 1ns / 1ps

module serial_bank_switch_mapper_core_tb;
  import sbsm_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  int                 fail_count;
  int                 pending_count;
  int                 accesses_sent = 0;
  int                 burst_left = 0;

  sbsm_in_if  access_ch ();
  sbsm_out_if result_ch ();

  serial_bank_switch_mapper_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (access_ch),
    .out_o       (result_ch)
  );

  serial_bank_switch_mapper_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .access_mon   (access_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("serial_bank_switch_mapper_core_tb: FAIL");
    $finish;
  end

  // The receiver switches between always ready, coin-flip stalls and long stalls.
  initial begin
    int stall_mode;
    int span;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall_mode = $urandom_range(0, 2);
      span = $urandom_range(8, 48);
      repeat (span) begin
        @(negedge clk_i);
        case (stall_mode)
          0: result_ch.ready = 1'b1;
          1: result_ch.ready = 1'($urandom_range(0, 1));
          default: result_ch.ready = ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic drive_access(input logic [1:0] op, input logic [15:0] addr,
                              input logic [7:0] data);
    @(negedge clk_i);
    access_ch.valid = 1'b1;
    access_ch.opcode = op;
    access_ch.bus_address = addr;
    access_ch.write_data = data;
    @(posedge clk_i);
    while (!access_ch.ready) @(posedge clk_i);
    accesses_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    access_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic paced_access(input logic [1:0] op, input logic [15:0] addr,
                              input logic [7:0] data);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    drive_access(op, addr, data);
  endtask

  task automatic drain_accesses();
    @(negedge clk_i);
    access_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Shifts a value in one bit per beat; break_at below 5 aborts with a reset write.
  task automatic load_register(input logic [1:0] sel, input logic [4:0] value,
                               input int break_at);
    logic [12:0] low_bits;
    logic [5:0]  filler;
    for (int i = 0; i < 5; i++) begin
      if (i == break_at) begin
        paced_access(OpCpuWr, 16'($urandom_range(16'h8000, 16'hFFFF)),
                     8'($urandom_range(8'h80, 8'hFF)));
        return;
      end
      if ($urandom_range(0, 5) == 0)
        paced_access(OpPpuRd, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
      low_bits = 13'($urandom_range(0, 16'h1FFF));
      filler = 6'($urandom);
      paced_access(OpCpuWr, {1'b1, sel, low_bits}, {1'b0, filler, value[i]});
    end
  endtask

  task automatic random_access();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      load_register(2'($urandom), 5'($urandom),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : 5);
    end else if (pick < 38) begin
      paced_access(OpCpuWr, 16'($urandom_range(16'h8000, 16'hFFFF)),
                   8'($urandom_range(8'h80, 8'hFF)));
    end else if (pick < 60) begin
      paced_access(OpCpuRd, ($urandom_range(0, 1) != 0) ?
                   16'($urandom_range(16'h8000, 16'hFFFF)) : 16'($urandom), 8'($urandom));
    end else if (pick < 68) begin
      paced_access(OpCpuWr, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
    end else begin
      paced_access(($urandom_range(0, 1) != 0) ? OpPpuWr : OpPpuRd,
                   ($urandom_range(0, 3) != 0) ?
                   16'($urandom_range(0, 16'h1FFF)) : 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [CfgW-1:0] prg_plan [6];
    logic [CfgW-1:0] chr_plan [6];
    int phase_end;
    prg_plan = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd2, 5'd16};
    chr_plan = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd0};
    prg_plan[5] = CfgW'($urandom_range(0, 31));
    chr_plan[5] = CfgW'($urandom_range(0, 31));
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgPrgBanks;
    cfg_wdata_i = '0;
    access_ch.valid = 1'b0;
    access_ch.opcode = OpCpuRd;
    access_ch.bus_address = '0;
    access_ch.write_data = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    paced_access(OpCpuRd, 16'h0000, 8'h00);
    paced_access(OpCpuWr, 16'h5FFF, 8'hFF);
    paced_access(OpCpuRd, 16'h6000, 8'h00);
    paced_access(OpCpuWr, 16'h7FFF, 8'hA5);
    paced_access(OpCpuRd, 16'h8000, 8'h00);
    paced_access(OpCpuRd, 16'hFFFF, 8'h00);
    paced_access(OpPpuRd, 16'h0000, 8'h00);
    paced_access(OpPpuWr, 16'h1FFF, 8'h5A);
    paced_access(OpPpuRd, 16'h2000, 8'h00);
    paced_access(OpPpuWr, 16'hFFFF, 8'hFF);
    paced_access(OpCpuWr, 16'h8000, 8'h80);
    load_register(SelControl, 5'h13, 5);
    load_register(SelChrHigh, 5'h1F, 5);
    paced_access(OpPpuRd, 16'h1000, 8'h00);
    paced_access(OpCpuWr, 16'hFFFF, 8'hFF);
    paced_access(OpCpuRd, 16'hC000, 8'h00);

    for (int p = 0; p < 6; p++) begin
      drain_accesses();
      write_cfg(CfgPrgBanks, prg_plan[p]);
      write_cfg(CfgChrBanks, chr_plan[p]);
      phase_end = accesses_sent + 88;
      while (accesses_sent < phase_end) random_access();
    end

    drain_accesses();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("serial_bank_switch_mapper_core_tb: PASS");
    end else begin
      $display("serial_bank_switch_mapper_core_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sbsm_pkg.sv
src/sbsm_if.sv
src/sbsm_front.sv
src/sbsm_queue.sv
src/sbsm_back.sv
src/serial_bank_switch_mapper_core.sv
src/sbsm_checker.sv
tb/serial_bank_switch_mapper_core_checker.sv
tb/serial_bank_switch_mapper_core_tb.sv
